[design/ixsl_pkg.sv]
// Package for the indexed shift list: operation and status codes, field widths
// and the per-cell command struct. Used by every module of the block.
package ixsl_pkg;

  // Default number of entries
  localparam int unsigned CAPACITY_DEF = 16;

  // Field widths of an item and a result
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Stream data widths, whole bytes
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  // Word returned by a read outside the list
  localparam logic [WORD_W-1:0] READ_FAIL = 32'h8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_REMOVE = 3'd2,
    FN_READ   = 3'd3,
    FN_WRITE  = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Command broadcast to every cell for one accepted item
  typedef struct packed {
    logic ins;  // shift right above position, load word at position
    logic rem;  // shift left from position upwards
    logic set;  // load word at position
  } cell_cmd_t;

endpackage

[design/ixsl_cell.sv]
// One storage cell of the indexed shift list: a single word with neighbour
// inputs for shifting. Depends on ixsl_pkg.
module ixsl_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 5
) (
  input  logic                      clk_i,
  input  ixsl_pkg::cell_cmd_t       cmd_i,
  input  logic [CW-1:0]             pos_i,
  input  logic [ixsl_pkg::WORD_W-1:0] word_i,
  input  logic [ixsl_pkg::WORD_W-1:0] left_i,   // entry of cell INDEX-1
  input  logic [ixsl_pkg::WORD_W-1:0] right_i,  // entry of cell INDEX+1
  output logic [ixsl_pkg::WORD_W-1:0] entry_o
);
  import ixsl_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [WORD_W-1:0] entry_q, entry_d;
  logic              at_pos, above_pos;

  assign at_pos    = (pos_i == IDX);
  assign above_pos = (IDX > pos_i);

  // Next value: load, take left neighbour, take right neighbour or hold
  always_comb begin
    entry_d = entry_q;
    if ((cmd_i.ins || cmd_i.set) && at_pos) begin
      entry_d = word_i;
    end else if (cmd_i.ins && above_pos) begin
      entry_d = left_i;
    end else if (cmd_i.rem && (at_pos || above_pos)) begin
      entry_d = right_i;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[design/ixsl_ctrl.sv]
// Control of the indexed shift list: stream handshake, operation decode,
// entry count, read select and result register. Depends on ixsl_pkg.
module ixsl_ctrl #(
  parameter int unsigned CAPACITY = ixsl_pkg::CAPACITY_DEF,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_tvalid_i,
  output logic                                   s_tready_o,
  input  logic [ixsl_pkg::IN_DATA_W-1:0]         s_tdata_i,
  output logic                                   m_tvalid_o,
  input  logic                                   m_tready_i,
  output logic [ixsl_pkg::OUT_DATA_W-1:0]        m_tdata_o,
  input  logic [CAPACITY-1:0][ixsl_pkg::WORD_W-1:0] entries_i,
  output ixsl_pkg::cell_cmd_t                    cmd_o,
  output logic [CW-1:0]                          pos_o,
  output logic [ixsl_pkg::WORD_W-1:0]            word_o
);
  import ixsl_pkg::*;

  // Compare width wide enough for both the position field and the count
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CMPW-1:0] CAP = CMPW'(CAPACITY);

  logic [FUNC_W-1:0]   func;
  logic [POS_W-1:0]    position;
  logic [WORD_W-1:0]   item;
  logic                accept;
  logic [CMPW-1:0]     pos_ext, cnt_ext;
  logic [CW-1:0]       count_q, count_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   value;
  status_e             status;
  cell_cmd_t           cmd;
  logic [CMPW-1:0]     tgt;
  logic [CMPW-1:0]     cnt_new;

  // Unpack the item
  assign func     = s_tdata_i[FUNC_W-1:0];
  assign position = s_tdata_i[FUNC_W +: POS_W];
  assign item     = s_tdata_i[FUNC_W+POS_W +: WORD_W];

  // Take an item whenever the result register is free or being drained
  assign s_tready_o = !m_valid_q || m_tready_i;
  assign accept     = s_tvalid_i && s_tready_o;

  assign pos_ext = CMPW'(position);
  assign cnt_ext = CMPW'(count_q);

  // Read select: one-hot AND-OR over the cells
  always_comb begin
    rd_word = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (pos_ext == CMPW'(i)) begin
        rd_word = rd_word | entries_i[i];
      end
    end
  end

  // Decode and status
  always_comb begin
    cmd     = '0;
    tgt     = pos_ext;
    value   = '0;
    status  = ST_OK;
    cnt_new = cnt_ext;
    case (func)
      FN_APPEND: begin
        tgt = cnt_ext;
        if (cnt_ext >= CAP) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_new = cnt_ext + 1'b1;
        end
      end
      FN_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_BOUNDS;
        end else if (cnt_ext >= CAP) begin
          status = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_new = cnt_ext + 1'b1;
        end
      end
      FN_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BOUNDS;
        end else begin
          cmd.rem = 1'b1;
          cnt_new = cnt_ext - 1'b1;
        end
      end
      FN_READ: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BOUNDS;
          value  = READ_FAIL;
        end else begin
          value = rd_word;
        end
      end
      FN_WRITE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BOUNDS;
        end else begin
          cmd.set = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Cells act only on an accepted item
  assign cmd_o  = accept ? cmd : '0;
  assign pos_o  = tgt[CW-1:0];
  assign word_o = item;

  assign count_d   = accept ? cnt_new[CW-1:0] : count_q;
  assign m_valid_d = accept ? 1'b1 : (m_valid_q && !m_tready_i);
  assign m_data_d  = {1'b0, cnt_new[COUNT_W-1:0], status, value};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

[design/indexed_shift_list.sv]
// Indexed shift list, top level: a row of word cells and the control unit.
// Depends on ixsl_pkg, ixsl_cell and ixsl_ctrl.
//
// An ordered list of up to CAPACITY signed 32-bit words. Each item appends,
// inserts, removes, reads or overwrites one entry and gives one result with
// the word read, a status (ok, index out of bounds, list full) and the entry
// count after the operation. Every entry sits in its own cell, and all cells
// shift or load at the same clock edge, so a new item is taken every cycle
// while the output is not stalled; its result is in the output register on
// the next cycle. The result register is the only buffer, so the input
// stalls while a result waits and the output is not taken. Positions reach
// 31 at most, and the reported count is the low five bits of the entry
// count. Entries need no clearing after reset.
module indexed_shift_list #(
  parameter int unsigned CAPACITY = ixsl_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // [2:0] func, [7:3] position, [39:8] item
  input  logic [ixsl_pkg::IN_DATA_W-1:0]  s_tdata_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // [31:0] read_value, [33:32] status, [38:34] count, [39] zero
  output logic [ixsl_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import ixsl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  cell_cmd_t                     cmd;
  logic [CW-1:0]                 pos;
  logic [WORD_W-1:0]             word;
  logic [CAPACITY-1:0][WORD_W-1:0] entries;

  // Control unit
  ixsl_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .entries_i  (entries),
    .cmd_o      (cmd),
    .pos_o      (pos),
    .word_o     (word)
  );

  // Row of cells, each wired to its two neighbours
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entries[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entries[g+1];
    end

    ixsl_cell #(
      .INDEX (g),
      .CW    (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .entry_o (entries[g])
    );
  end

endmodule
